>>> sv/gts_pkg.sv
`default_nettype none

package gts_pkg;

    localparam int GRID_X_DEF = 32;
    localparam int GRID_Y_DEF = 32;
    localparam int GRID_Z_DEF = 32;

    localparam int DATA_W  = 32;
    localparam int CELL_W  = 5;
    localparam int FRAC_W  = 16;
    localparam int PADDR_W = 5;
    localparam int CORNERS = 8;

    localparam logic [DATA_W-1:0] SCALE_RST = 32'h0001_0000;

    localparam logic [2:0] REG_X_ORIGIN = 3'd0;
    localparam logic [2:0] REG_Y_ORIGIN = 3'd1;
    localparam logic [2:0] REG_Z_ORIGIN = 3'd2;
    localparam logic [2:0] REG_X_SCALE  = 3'd3;
    localparam logic [2:0] REG_Y_SCALE  = 3'd4;
    localparam logic [2:0] REG_Z_SCALE  = 3'd5;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_MUL  = 7'b0000010,
        S_CHK  = 7'b0000100,
        S_ADDR = 7'b0001000,
        S_RD   = 7'b0010000,
        S_BMUL = 7'b0100000,
        S_BADD = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

>>> sv/grid_trilinear_sampler.sv
// A request is taken at a clock edge with start high and busy low. A write request stores
// one cell if its coordinates lie inside the grid, and its result (density 0, outside 0)
// appears in the next cycle. A sample request keeps busy high while one shared multiplier
// maps the three axes (a multiply and a check state per axis); for an interior sample,
// eight corners are then read from the single-port grid memory, one read per cycle, and the
// same multiplier performs the seven blends, each in a multiply state and an add state. A
// sample at the upper edge of an axis reads only the base cell and returns it unblended; a
// sample outside the grid ends at the check of the first failing axis. Each result is shown
// for exactly one cycle with o_strobe high, and the receiver cannot stall it, so it must
// capture every strobe. The next request may be issued in the cycle that carries the result.
`default_nettype none

module grid_trilinear_sampler #(
    parameter int GRID_X = gts_pkg::GRID_X_DEF,
    parameter int GRID_Y = gts_pkg::GRID_Y_DEF,
    parameter int GRID_Z = gts_pkg::GRID_Z_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic                               i_cmd,
    input  logic        [gts_pkg::CELL_W-1:0]  i_cell_x,
    input  logic        [gts_pkg::CELL_W-1:0]  i_cell_y,
    input  logic        [gts_pkg::CELL_W-1:0]  i_cell_z,
    input  logic signed [gts_pkg::DATA_W-1:0]  i_cell_value,
    input  logic signed [gts_pkg::DATA_W-1:0]  i_pos_x,
    input  logic signed [gts_pkg::DATA_W-1:0]  i_pos_y,
    input  logic signed [gts_pkg::DATA_W-1:0]  i_pos_z,
    output logic                               o_strobe,
    output logic signed [gts_pkg::DATA_W-1:0]  o_density,
    output logic                               o_outside,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic        [gts_pkg::PADDR_W-1:0] paddr,
    input  logic        [gts_pkg::DATA_W-1:0]  pwdata,
    output logic        [gts_pkg::DATA_W-1:0]  prdata,
    output logic                               pready
);

    import gts_pkg::*;

    localparam int GYZ   = GRID_Y * GRID_Z;
    localparam int DEPTH = GRID_X * GYZ;
    localparam int AW    = $clog2(DEPTH);
    localparam int GXY   = (GRID_X > GRID_Y) ? GRID_X : GRID_Y;
    localparam int GMAX  = (GXY > GRID_Z) ? GXY : GRID_Z;
    localparam int LW    = $clog2(GMAX);
    localparam int DW    = DATA_W;
    localparam int PW    = 2 * DW + 2;

    logic signed [DW-1:0] r_x_origin;
    logic signed [DW-1:0] r_y_origin;
    logic signed [DW-1:0] r_z_origin;
    logic        [DW-1:0] r_x_scale;
    logic        [DW-1:0] r_y_scale;
    logic        [DW-1:0] r_z_scale;

    t_state               r_state;
    t_state               n_state;
    logic [1:0]           r_axis;
    logic [3:0]           r_cnt;
    logic [3:0]           r_nrd;
    logic [3:0]           r_len;
    logic                 r_edge;
    logic                 r_strobe;
    logic signed [DW-1:0] r_density;
    logic                 r_outside;

    logic signed [DW:0]   r_d    [3];
    logic [LW-1:0]        r_lo   [3];
    logic [FRAC_W-1:0]    r_frac [3];
    logic signed [PW-1:0] r_prod;
    logic [AW-1:0]        r_base;
    logic [DW-1:0]        r_q    [CORNERS];

    logic                 req;
    logic                 wr_req;
    logic                 smp_req;
    logic                 wr_ok;
    logic                 cfg_wr;
    logic [AW-1:0]        wr_addr;
    logic [AW-1:0]        c_addr;
    logic [AW-1:0]        ram_addr;
    logic                 ram_we;
    logic [DW-1:0]        ram_rdata;

    logic [DW-1:0]        sel_scale;
    logic [DW-1:0]        sel_nm1;
    logic signed [DW:0]   sel_d;
    logic [2*DW-1:0]      t_val;
    logic                 ax_out;
    logic [FRAC_W-1:0]    blend_f;
    logic signed [DW:0]   mul_a;
    logic signed [DW:0]   mul_b;
    logic signed [PW-1:0] mul_p;
    logic [DW:0]          blend_sum;
    logic [DW-1:0]        blend_res;
    logic [2:0]           wr_slot;
    logic                 rd_done;
    logic                 last_blend;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin <= '0;
            r_y_origin <= '0;
            r_z_origin <= '0;
            r_x_scale  <= SCALE_RST;
            r_y_scale  <= SCALE_RST;
            r_z_scale  <= SCALE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[PADDR_W-1:2])
                REG_X_ORIGIN: r_x_origin <= pwdata;
                REG_Y_ORIGIN: r_y_origin <= pwdata;
                REG_Z_ORIGIN: r_z_origin <= pwdata;
                REG_X_SCALE:  r_x_scale  <= pwdata;
                REG_Y_SCALE:  r_y_scale  <= pwdata;
                REG_Z_SCALE:  r_z_scale  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[PADDR_W-1:2])
            REG_X_ORIGIN: prdata = r_x_origin;
            REG_Y_ORIGIN: prdata = r_y_origin;
            REG_Z_ORIGIN: prdata = r_z_origin;
            REG_X_SCALE:  prdata = r_x_scale;
            REG_Y_SCALE:  prdata = r_y_scale;
            REG_Z_SCALE:  prdata = r_z_scale;
            default:      prdata = '0;
        endcase
    end

    assign busy    = (r_state != S_IDLE);
    assign req     = start && !busy;
    assign wr_req  = req && (i_cmd == CMD_WRITE);
    assign smp_req = req && (i_cmd == CMD_SAMPLE);

    assign wr_ok = (32'(i_cell_x) < GRID_X) && (32'(i_cell_y) < GRID_Y)
                   && (32'(i_cell_z) < GRID_Z);
    assign wr_addr = AW'(32'(i_cell_x) * GYZ + 32'(i_cell_y) * GRID_Z + 32'(i_cell_z));

    assign c_addr = r_base + (r_cnt[2] ? AW'(GYZ) : '0) + (r_cnt[1] ? AW'(GRID_Z) : '0)
                    + AW'(r_cnt[0]);

    assign ram_addr = (r_state == S_RD) ? c_addr : wr_addr;
    assign ram_we   = wr_req && wr_ok;

    gts_ram #(
        .WIDTH(DW),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(i_cell_value),
        .o_rdata(ram_rdata)
    );

    always_comb begin
        case (r_axis)
            AXIS_X: begin
                sel_scale = r_x_scale;
                sel_nm1   = 32'(GRID_X - 1);
            end
            AXIS_Y: begin
                sel_scale = r_y_scale;
                sel_nm1   = 32'(GRID_Y - 1);
            end
            default: begin
                sel_scale = r_z_scale;
                sel_nm1   = 32'(GRID_Z - 1);
            end
        endcase
    end

    assign sel_d  = r_d[r_axis];
    assign t_val  = (sel_scale == '0) ? '0 : r_prod[2*DW-1:0];
    assign ax_out = ((sel_scale != '0) && sel_d[DW])
                    || (t_val[2*DW-1:DW] > sel_nm1)
                    || ((t_val[2*DW-1:DW] == sel_nm1) && (t_val[DW-1:0] != '0));

    always_comb begin
        if (r_len >= 4'd5) begin
            blend_f = r_frac[AXIS_Z];
        end else if (r_len >= 4'd3) begin
            blend_f = r_frac[AXIS_Y];
        end else begin
            blend_f = r_frac[AXIS_X];
        end
    end

    always_comb begin
        if (r_state == S_BMUL) begin
            mul_a = $signed({r_q[1][DW-1], r_q[1]}) - $signed({r_q[0][DW-1], r_q[0]});
            mul_b = $signed({{(DW + 1 - FRAC_W){1'b0}}, blend_f});
        end else begin
            mul_a = $signed({1'b0, sel_d[DW-1:0]});
            mul_b = $signed({1'b0, sel_scale});
        end
    end

    assign mul_p      = mul_a * mul_b;
    assign blend_sum  = {r_q[0][DW-1], r_q[0]} + r_prod[DW+FRAC_W:FRAC_W];
    assign blend_res  = blend_sum[DW-1:0];
    assign wr_slot    = 3'(r_len - 4'd2);
    assign rd_done    = (r_cnt == r_nrd);
    assign last_blend = (r_len == 4'd2);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (smp_req) n_state = S_MUL;
            S_MUL:  n_state = S_CHK;
            S_CHK: begin
                if (ax_out) begin
                    n_state = S_IDLE;
                end else if (r_axis == AXIS_Z) begin
                    n_state = S_ADDR;
                end else begin
                    n_state = S_MUL;
                end
            end
            S_ADDR: n_state = S_RD;
            S_RD:   if (rd_done) n_state = r_edge ? S_IDLE : S_BMUL;
            S_BMUL: n_state = S_BADD;
            S_BADD: n_state = last_blend ? S_IDLE : S_BMUL;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_axis   <= AXIS_X;
            r_cnt    <= '0;
            r_len    <= '0;
        end else begin
            r_state  <= n_state;
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (wr_req) begin
                        r_strobe  <= 1'b1;
                        r_density <= '0;
                        r_outside <= 1'b0;
                    end
                    if (smp_req) begin
                        r_axis <= AXIS_X;
                        r_d[AXIS_X] <= $signed({i_pos_x[DW-1], i_pos_x})
                                       - $signed({r_x_origin[DW-1], r_x_origin});
                        r_d[AXIS_Y] <= $signed({i_pos_y[DW-1], i_pos_y})
                                       - $signed({r_y_origin[DW-1], r_y_origin});
                        r_d[AXIS_Z] <= $signed({i_pos_z[DW-1], i_pos_z})
                                       - $signed({r_z_origin[DW-1], r_z_origin});
                    end
                end
                S_MUL: begin
                    r_prod <= mul_p;
                end
                S_CHK: begin
                    if (ax_out) begin
                        r_strobe  <= 1'b1;
                        r_density <= '0;
                        r_outside <= 1'b1;
                    end else begin
                        r_lo[r_axis]   <= t_val[DW +: LW];
                        r_frac[r_axis] <= t_val[DW-1 -: FRAC_W];
                        r_axis         <= r_axis + 2'd1;
                    end
                end
                S_ADDR: begin
                    r_base <= AW'(32'(r_lo[AXIS_X]) * GYZ + 32'(r_lo[AXIS_Y]) * GRID_Z
                                  + 32'(r_lo[AXIS_Z]));
                    r_edge <= (r_lo[AXIS_X] == LW'(GRID_X - 1))
                              || (r_lo[AXIS_Y] == LW'(GRID_Y - 1))
                              || (r_lo[AXIS_Z] == LW'(GRID_Z - 1));
                    r_nrd  <= ((r_lo[AXIS_X] == LW'(GRID_X - 1))
                              || (r_lo[AXIS_Y] == LW'(GRID_Y - 1))
                              || (r_lo[AXIS_Z] == LW'(GRID_Z - 1))) ? 4'd1 : 4'(CORNERS);
                    r_cnt  <= '0;
                end
                S_RD: begin
                    if (r_cnt != '0) begin
                        for (int i = 0; i < CORNERS - 1; i++) begin
                            r_q[i] <= r_q[i+1];
                        end
                        r_q[CORNERS-1] <= ram_rdata;
                    end
                    r_cnt <= r_cnt + 4'd1;
                    if (rd_done) begin
                        r_len <= 4'(CORNERS);
                        if (r_edge) begin
                            r_strobe  <= 1'b1;
                            r_density <= ram_rdata;
                            r_outside <= 1'b0;
                        end
                    end
                end
                S_BMUL: begin
                    r_prod <= mul_p;
                end
                S_BADD: begin
                    for (int i = 0; i < CORNERS - 2; i++) begin
                        r_q[i] <= r_q[i+2];
                    end
                    r_q[wr_slot] <= blend_res;
                    r_len <= r_len - 4'd1;
                    if (last_blend) begin
                        r_strobe  <= 1'b1;
                        r_density <= blend_res;
                        r_outside <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_strobe  = r_strobe;
    assign o_density = r_density;
    assign o_outside = r_outside;

endmodule

`default_nettype wire

>>> sv/gts_ram.sv
`default_nettype none

module gts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> sv/gts_checker.sv
`default_nettype none

module gts_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic                       i_cmd,
    input logic                       o_strobe,
    input logic [gts_pkg::DATA_W-1:0] o_density,
    input logic                       o_outside
);

    import gts_pkg::*;

    // A write request returns an all-zero result in the next cycle.
    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && start && !busy && (i_cmd == CMD_WRITE))
        |=> (o_strobe && (o_density == '0) && !o_outside))
        else $error("write request did not return a zero result in the next cycle");

    // A sample request keeps the block busy, with no result, in the cycle after it is taken.
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && start && !busy && (i_cmd == CMD_SAMPLE)) |=> (busy && !o_strobe))
        else $error("sample request did not raise busy");

    // The end of a sample is always marked by its result.
    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $fell(busy)) |-> o_strobe)
        else $error("busy fell without a result");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_outside) |-> (o_density == '0))
        else $error("outside result carries a nonzero density");

    // No result appears without a request in progress.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && o_strobe) |-> ($past(start && !busy) || $past(busy)))
        else $error("result strobe without a request");

endmodule

bind grid_trilinear_sampler gts_checker u_gts_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_cmd    (i_cmd),
    .o_strobe (o_strobe),
    .o_density(o_density),
    .o_outside(o_outside)
);

`default_nettype wire

>>> test/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gts_pkg::*;

    localparam int GX = GRID_X_DEF;
    localparam int GY = GRID_Y_DEF;
    localparam int GZ = GRID_Z_DEF;
    localparam int DEPTH = GX * GY * GZ;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int TAIL_CYCLES = 40;
    localparam int ITEMS_PER_PHASE = 480;

    typedef struct {
        logic              cmd;
        logic [CELL_W-1:0] cx;
        logic [CELL_W-1:0] cy;
        logic [CELL_W-1:0] cz;
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] px;
        logic [DATA_W-1:0] py;
        logic [DATA_W-1:0] pz;
    } t_grid_request;

    typedef struct {
        logic [DATA_W-1:0] density;
        logic              outside;
    } t_density_result;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic                i_cmd = CMD_WRITE;
    logic [CELL_W-1:0]   i_cell_x = '0;
    logic [CELL_W-1:0]   i_cell_y = '0;
    logic [CELL_W-1:0]   i_cell_z = '0;
    logic [DATA_W-1:0]   i_cell_value = '0;
    logic [DATA_W-1:0]   i_pos_x = '0;
    logic [DATA_W-1:0]   i_pos_y = '0;
    logic [DATA_W-1:0]   i_pos_z = '0;
    logic                o_strobe;
    logic [DATA_W-1:0]   o_density;
    logic                o_outside;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    logic [DATA_W-1:0]   grid_shadow [DEPTH];
    bit                  cell_written [DEPTH];
    logic [DATA_W-1:0]   cfg_regs [6];
    int                  window_base [3];
    t_density_result     expected_results [$];
    int                  fail_count = 0;
    int                  items_sent = 0;
    int                  idle_pct = 0;
    int                  cycle_count = 0;
    bit                  start_high = 1'b0;

    grid_trilinear_sampler dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_cmd        (i_cmd),
        .i_cell_x     (i_cell_x),
        .i_cell_y     (i_cell_y),
        .i_cell_z     (i_cell_z),
        .i_cell_value (i_cell_value),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .i_pos_z      (i_pos_z),
        .o_strobe     (o_strobe),
        .o_density    (o_density),
        .o_outside    (o_outside),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("grid_trilinear_sampler test failed");
            $finish;
        end
    end

    function automatic int unsigned cell_index(input int unsigned x, input int unsigned y,
                                               input int unsigned z);
        return (x * GY + y) * GZ + z;
    endfunction

    function automatic longint cell_at(input int unsigned x, input int unsigned y,
                                       input int unsigned z);
        longint v;
        v = $signed(grid_shadow[cell_index(x, y, z)]);
        return v;
    endfunction

    function automatic longint mix(input longint a, input longint b, input logic [FRAC_W-1:0] f);
        longint p;
        p = (b - a) * longint'(f);
        return a + (p >>> FRAC_W);
    endfunction

    function automatic logic map_axis(input logic [DATA_W-1:0] pos,
                                      input logic [DATA_W-1:0] origin,
                                      input logic [DATA_W-1:0] scale, input int n,
                                      output int unsigned lo, output logic [FRAC_W-1:0] frac);
        logic signed [DATA_W:0] d;
        logic [63:0]            t;
        d = $signed({pos[DATA_W-1], pos}) - $signed({origin[DATA_W-1], origin});
        lo = 0;
        frac = '0;
        if (scale == '0) begin
            t = '0;
        end else if (d < 0) begin
            return 1'b0;
        end else begin
            t = {32'b0, d[DATA_W-1:0]} * {32'b0, scale};
        end
        if (t > (64'(n - 1) << 32)) return 1'b0;
        lo = t[63:32];
        frac = t[31:16];
        return 1'b1;
    endfunction

    function automatic t_density_result predict_density(input t_grid_request req);
        t_density_result   res;
        int unsigned       xl, yl, zl;
        logic [FRAC_W-1:0] xf, yf, zf;
        logic              in_x, in_y, in_z;
        longint            i1, i2, j1, j2, w1, w2, dens;
        int unsigned       idx;
        res.density = '0;
        res.outside = 1'b0;
        if (req.cmd == CMD_WRITE) begin
            if (req.cx < GX && req.cy < GY && req.cz < GZ) begin
                idx = cell_index(req.cx, req.cy, req.cz);
                grid_shadow[idx] = req.value;
                cell_written[idx] = 1'b1;
            end
            return res;
        end
        in_x = map_axis(req.px, cfg_regs[REG_X_ORIGIN], cfg_regs[REG_X_SCALE], GX, xl, xf);
        in_y = map_axis(req.py, cfg_regs[REG_Y_ORIGIN], cfg_regs[REG_Y_SCALE], GY, yl, yf);
        in_z = map_axis(req.pz, cfg_regs[REG_Z_ORIGIN], cfg_regs[REG_Z_SCALE], GZ, zl, zf);
        if (!(in_x && in_y && in_z)) begin
            res.outside = 1'b1;
            return res;
        end
        if (xl + 1 < GX && yl + 1 < GY && zl + 1 < GZ) begin
            i1 = mix(cell_at(xl, yl, zl), cell_at(xl, yl, zl + 1), zf);
            i2 = mix(cell_at(xl, yl + 1, zl), cell_at(xl, yl + 1, zl + 1), zf);
            j1 = mix(cell_at(xl + 1, yl, zl), cell_at(xl + 1, yl, zl + 1), zf);
            j2 = mix(cell_at(xl + 1, yl + 1, zl), cell_at(xl + 1, yl + 1, zl + 1), zf);
            w1 = mix(i1, i2, yf);
            w2 = mix(j1, j2, yf);
            dens = mix(w1, w2, xf);
        end else begin
            dens = cell_at(xl, yl, zl);
        end
        if (dens[63:31] != {33{dens[31]}})
            res.density = dens[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            res.density = dens[31:0];
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] random_value();
        case ($urandom_range(9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2, 3, 4: return $urandom_range(0, 32'h001F_FFFF) - 32'h0010_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] pick_position(input logic [DATA_W-1:0] origin,
                                                        input logic [DATA_W-1:0] scale,
                                                        input int n, input int base);
        logic [63:0] target, d;
        longint      p;
        int unsigned lo;
        int          r;
        r = $urandom_range(99);
        if (r < 8 || scale == '0) return $urandom;
        if (r < 11) begin
            p = longint'($signed(origin)) - 1;
        end else begin
            if (r < 15) begin
                d = ((64'(n - 1) << 32) / scale) + 1;
            end else begin
                if (r < 20) begin
                    target = 64'(n - 1) << 32;
                end else begin
                    lo = (r < 70) ? base + $urandom_range(0, 3) : $urandom_range(0, n - 1);
                    target = (64'(lo) << 32) | 64'($urandom);
                    if (lo == n - 1) target[31:0] = '0;
                end
                d = target / scale;
            end
            if (d > 64'h1_FFFF_FFFF) return $urandom;
            p = longint'($signed(origin)) + longint'(d);
        end
        if (p[63:31] != {33{p[31]}}) return $urandom;
        return p[31:0];
    endfunction

    always @(posedge i_clk) begin
        t_density_result want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual density %h outside %b",
                         $time, o_density, o_outside);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_density !== want.density) begin
                    $display("%0t: density mismatch, expected %h actual %h",
                             $time, want.density, o_density);
                    fail_count++;
                end
                if (o_outside !== want.outside) begin
                    $display("%0t: outside mismatch, expected %b actual %b",
                             $time, want.outside, o_outside);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_request(input t_grid_request req);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
            if (start_high) begin
                start <= 1'b0;
                start_high = 1'b0;
            end
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        start_high = 1'b1;
        i_cmd <= req.cmd;
        i_cell_x <= req.cx;
        i_cell_y <= req.cy;
        i_cell_z <= req.cz;
        i_cell_value <= req.value;
        i_pos_x <= req.px;
        i_pos_y <= req.py;
        i_pos_z <= req.pz;
        do @(posedge i_clk); while (busy !== 1'b0);
        expected_results.push_back(predict_density(req));
        items_sent++;
    endtask

    task automatic drain_requests();
        if (start_high) begin
            start <= 1'b0;
            start_high = 1'b0;
        end
        while (expected_results.size() != 0 || busy !== 1'b0) @(posedge i_clk);
    endtask

    task automatic write_cell(input logic [CELL_W-1:0] x, input logic [CELL_W-1:0] y,
                              input logic [CELL_W-1:0] z, input logic [DATA_W-1:0] value);
        t_grid_request req;
        req.cmd = CMD_WRITE;
        req.cx = x;
        req.cy = y;
        req.cz = z;
        req.value = value;
        req.px = $urandom;
        req.py = $urandom;
        req.pz = $urandom;
        send_request(req);
    endtask

    // Every cell that the sample will read must hold a written value first.
    task automatic fill_corners(input logic [DATA_W-1:0] px, input logic [DATA_W-1:0] py,
                                input logic [DATA_W-1:0] pz);
        int unsigned       xl, yl, zl, idx;
        logic [FRAC_W-1:0] xf, yf, zf;
        logic              in_x, in_y, in_z;
        in_x = map_axis(px, cfg_regs[REG_X_ORIGIN], cfg_regs[REG_X_SCALE], GX, xl, xf);
        in_y = map_axis(py, cfg_regs[REG_Y_ORIGIN], cfg_regs[REG_Y_SCALE], GY, yl, yf);
        in_z = map_axis(pz, cfg_regs[REG_Z_ORIGIN], cfg_regs[REG_Z_SCALE], GZ, zl, zf);
        if (!(in_x && in_y && in_z)) return;
        for (int dx = 0; dx < 2; dx++) begin
            for (int dy = 0; dy < 2; dy++) begin
                for (int dz = 0; dz < 2; dz++) begin
                    if (xl + dx < GX && yl + dy < GY && zl + dz < GZ) begin
                        idx = cell_index(xl + dx, yl + dy, zl + dz);
                        if (!cell_written[idx])
                            write_cell(5'(xl + dx), 5'(yl + dy), 5'(zl + dz), random_value());
                    end
                end
            end
        end
    endtask

    task automatic sample_at(input logic [DATA_W-1:0] px, input logic [DATA_W-1:0] py,
                             input logic [DATA_W-1:0] pz);
        t_grid_request req;
        fill_corners(px, py, pz);
        req.cmd = CMD_SAMPLE;
        req.cx = 5'($urandom);
        req.cy = 5'($urandom);
        req.cz = 5'($urandom);
        req.value = $urandom;
        req.px = px;
        req.py = py;
        req.pz = pz;
        send_request(req);
    endtask

    task automatic apb_write(input logic [2:0] reg_idx, input logic [DATA_W-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_idx, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        cfg_regs[reg_idx] = data;
    endtask

    task automatic apb_read(input logic [2:0] reg_idx);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {reg_idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel <= 1'b0;
        penable <= 1'b0;
        if (prdata !== cfg_regs[reg_idx]) begin
            $display("%0t: register %0d readback mismatch, expected %h actual %h",
                     $time, reg_idx, cfg_regs[reg_idx], prdata);
            fail_count++;
        end
    endtask

    task automatic check_register(input logic [2:0] reg_idx, input logic [DATA_W-1:0] pattern);
        apb_read(reg_idx);
        apb_write(reg_idx, pattern);
        apb_read(reg_idx);
    endtask

    task automatic load_default_config();
        apb_write(REG_X_ORIGIN, '0);
        apb_write(REG_Y_ORIGIN, '0);
        apb_write(REG_Z_ORIGIN, '0);
        apb_write(REG_X_SCALE, SCALE_RST);
        apb_write(REG_Y_SCALE, SCALE_RST);
        apb_write(REG_Z_SCALE, SCALE_RST);
    endtask

    task automatic pick_axis(input logic [2:0] origin_reg, input logic [2:0] scale_reg,
                             input logic [1:0] axis, input int n);
        logic [DATA_W-1:0] origin, scale;
        case ($urandom_range(9))
            0, 1, 2, 3: begin
                origin = '0;
                scale = SCALE_RST;
            end
            4, 5, 6: begin
                origin = $urandom;
                scale = $urandom_range(32'h0000_1000, 32'h0010_0000);
            end
            default: begin
                case ($urandom_range(3))
                    0: origin = 32'h8000_0000;
                    1: origin = 32'h7FFF_FFFF;
                    2: origin = '0;
                    default: origin = $urandom;
                endcase
                case ($urandom_range(3))
                    0: scale = '0;
                    1: scale = 32'hFFFF_FFFF;
                    2: scale = 32'd1;
                    default: scale = $urandom;
                endcase
            end
        endcase
        apb_write(origin_reg, origin);
        apb_write(scale_reg, scale);
        window_base[axis] = $urandom_range(0, n - 4);
    endtask

    task automatic test_register_access();
        check_register(REG_X_ORIGIN, 32'hA5A5_5A5A);
        check_register(REG_Y_ORIGIN, 32'h5A5A_A5A5);
        check_register(REG_Z_ORIGIN, 32'hFFFF_0001);
        check_register(REG_X_SCALE, 32'h8000_0001);
        check_register(REG_Y_SCALE, 32'h0123_4567);
        check_register(REG_Z_SCALE, 32'hFEDC_BA98);
        load_default_config();
    endtask

    task automatic test_edges_and_bounds();
        // The eight corners of the first cell get alternating extremes so that its blends span the full range.
        for (int c = 0; c < CORNERS; c++)
            write_cell(5'(c / 4), 5'((c / 2) % 2), 5'(c % 2),
                       (((c / 4) + (c / 2) + c) % 2 == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
        write_cell(5'(GX - 1), 5'(GY - 1), 5'(GZ - 1), 32'h8000_0000);
        sample_at(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
        sample_at(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        sample_at(32'h0000_FFFF, 32'h0000_0001, 32'h0000_C000);
        sample_at(32'h001F_0000, 32'h001F_0000, 32'h001F_0000);
        sample_at(32'h001F_0000, 32'h0000_0000, 32'h0000_0000);
        sample_at(32'h001E_8000, 32'h001F_0000, 32'h0000_4000);
        sample_at(32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000);
        sample_at(32'h001F_0001, 32'h0000_0000, 32'h0000_0000);
        sample_at(32'h0000_0000, 32'h0000_0000, 32'h001F_0001);
        sample_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        sample_at(32'h0000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        drain_requests();
    endtask

    task automatic test_scale_extremes();
        drain_requests();
        apb_write(REG_X_SCALE, '0);
        apb_write(REG_Y_SCALE, '0);
        apb_write(REG_Z_SCALE, '0);
        sample_at(32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678);
        drain_requests();
        apb_write(REG_X_ORIGIN, 32'h8000_0000);
        apb_write(REG_X_SCALE, 32'hFFFF_FFFF);
        apb_write(REG_Y_ORIGIN, 32'h7FFF_FFFF);
        apb_write(REG_Y_SCALE, SCALE_RST);
        apb_write(REG_Z_ORIGIN, 32'hFFF0_0000);
        apb_write(REG_Z_SCALE, 32'h0000_8000);
        sample_at(32'h8000_001F, 32'h7FFF_FFFF, 32'h0000_0000);
        sample_at(32'h8000_0020, 32'h7FFF_FFFF, 32'h0000_0000);
        sample_at(32'h8000_0000, 32'h7FFF_FFFE, 32'h002E_0000);
        drain_requests();
        load_default_config();
    endtask

    task automatic test_random_traffic(input int pct);
        int phase_end, round_end, r;
        idle_pct = pct;
        phase_end = items_sent + ITEMS_PER_PHASE;
        while (items_sent < phase_end) begin
            drain_requests();
            pick_axis(REG_X_ORIGIN, REG_X_SCALE, AXIS_X, GX);
            pick_axis(REG_Y_ORIGIN, REG_Y_SCALE, AXIS_Y, GY);
            pick_axis(REG_Z_ORIGIN, REG_Z_SCALE, AXIS_Z, GZ);
            round_end = items_sent + $urandom_range(30, 90);
            while (items_sent < round_end && items_sent < phase_end) begin
                r = $urandom_range(99);
                if (r < 3) begin
                    drain_requests();
                end else if (r < 18) begin
                    write_cell(5'($urandom), 5'($urandom), 5'($urandom), random_value());
                end else begin
                    sample_at(pick_position(cfg_regs[REG_X_ORIGIN], cfg_regs[REG_X_SCALE], GX,
                                            window_base[AXIS_X]),
                              pick_position(cfg_regs[REG_Y_ORIGIN], cfg_regs[REG_Y_SCALE], GY,
                                            window_base[AXIS_Y]),
                              pick_position(cfg_regs[REG_Z_ORIGIN], cfg_regs[REG_Z_SCALE], GZ,
                                            window_base[AXIS_Z]));
                end
            end
        end
        drain_requests();
    endtask

    initial begin
        cfg_regs[REG_X_ORIGIN] = '0;
        cfg_regs[REG_Y_ORIGIN] = '0;
        cfg_regs[REG_Z_ORIGIN] = '0;
        cfg_regs[REG_X_SCALE] = SCALE_RST;
        cfg_regs[REG_Y_SCALE] = SCALE_RST;
        cfg_regs[REG_Z_SCALE] = SCALE_RST;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_register_access();
        test_edges_and_bounds();
        test_scale_extremes();
        test_random_traffic(20);
        test_random_traffic(45);
        test_random_traffic(0);
        drain_requests();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("grid_trilinear_sampler test passed");
        end else begin
            $display("grid_trilinear_sampler test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
sv/gts_pkg.sv
sv/gts_ram.sv
sv/grid_trilinear_sampler.sv
sv/gts_checker.sv
test/tb.sv
